// ===== sv/wsd_pkg.sv =====
// shared types, codes and constants of the websocket frame deframer
package wsd_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned LenW     = 7;
	localparam int unsigned KeyW     = 32;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned PhaseW   = 3;

	// header constants
	localparam logic [ByteW-1:0] FinBit      = 8'h80;
	localparam logic [ByteW-1:0] OpcodeMask  = 8'h0F;
	localparam logic [ByteW-1:0] OpcodeText  = 8'h01;
	localparam logic [ByteW-1:0] LenMask     = 8'h7F;
	localparam logic [LenW-1:0]  MaxLen      = 7'd125;

	// receive phases
	localparam logic [PhaseW-1:0] PH_HDR0 = 3'd0;
	localparam logic [PhaseW-1:0] PH_HDR1 = 3'd1;
	localparam logic [PhaseW-1:0] PH_MASK = 3'd2;
	localparam logic [PhaseW-1:0] PH_DATA = 3'd3;
	localparam logic [PhaseW-1:0] PH_SKIP = 3'd4;

	// result status codes
	localparam logic [StatusW-1:0] ST_PAYLOAD = 2'd0;
	localparam logic [StatusW-1:0] ST_EMPTY   = 2'd1;
	localparam logic [StatusW-1:0] ST_INVALID = 2'd2;
	localparam logic [StatusW-1:0] ST_TRUNC   = 2'd3;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             buf_end;
	} in_beat_t;

	typedef struct packed {
		logic               valid;
		logic [ByteW-1:0]   payload;
		logic               last;
		logic [StatusW-1:0] status;
	} result_t;

endpackage

// ===== sv/wsd_in_stage.sv =====
// input register stage of the websocket frame deframer
module wsd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,
	input  logic              s_axis_tlast,
	input  logic              advance,
	output logic              valid_s1,
	output wsd_pkg::in_beat_t beat_s1
);
	import wsd_pkg::*;

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			beat_s1.data    <= s_axis_tdata;
			beat_s1.buf_end <= s_axis_tlast;
		end
	end

endmodule

// ===== sv/wsd_parse.sv =====
// frame state and per-byte header check and unmasking
module wsd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  wsd_pkg::in_beat_t beat_s1,
	output wsd_pkg::result_t  res
);
	import wsd_pkg::*;

	logic [PhaseW-1:0] phase_q, phase_d;
	logic [KeyW-1:0]   key_q, key_d;
	logic [LenW-1:0]   left_q, left_d;
	logic [1:0]        pos_q, pos_d;
	logic              bad_q, bad_d;

	always_comb begin
		logic [ByteW-1:0] b;
		logic             e;
		logic [ByteW-1:0] k;
		logic [LenW-1:0]  dec;
		b       = beat_s1.data;
		e       = beat_s1.buf_end;
		k       = '0;
		dec     = left_q - 7'd1;
		phase_d = phase_q;
		key_d   = key_q;
		left_d  = left_q;
		pos_d   = pos_q;
		bad_d   = bad_q;
		res     = '0;
		case (phase_q)
			PH_HDR0: begin
				bad_d   = !(((b & FinBit) == FinBit) && ((b & OpcodeMask) == OpcodeText));
				pos_d   = 2'd0;
				phase_d = PH_HDR1;
				if (e) begin
					res.valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_INVALID;
				end
			end
			PH_HDR1: begin
				left_d = b[LenW-1:0] & LenMask[LenW-1:0];
				if (left_d > MaxLen) begin
					bad_d = 1'b1;
				end
				pos_d   = 2'd0;
				phase_d = PH_MASK;
				if (e) begin
					res.valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_INVALID;
				end
			end
			PH_MASK: begin
				key_d = {key_q[KeyW-ByteW-1:0], b};
				if (pos_q != 2'd3) begin
					pos_d = pos_q + 2'd1;
					if (e) begin
						res.valid  = 1'b1;
						res.last   = 1'b1;
						res.status = ST_INVALID;
					end
				end else begin
					pos_d = 2'd0;
					// header complete: decide on the frame
					if (bad_q) begin
						res.valid  = 1'b1;
						res.last   = 1'b1;
						res.status = ST_INVALID;
						phase_d    = PH_SKIP;
					end else if (left_q == '0) begin
						res.valid  = 1'b1;
						res.last   = 1'b1;
						res.status = ST_EMPTY;
						phase_d    = PH_SKIP;
					end else if (e) begin
						res.valid  = 1'b1;
						res.last   = 1'b1;
						res.status = ST_TRUNC;
						phase_d    = PH_SKIP;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (e && (left_q > 7'd1)) begin
					res.valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_TRUNC;
					phase_d    = PH_SKIP;
				end else begin
					case (pos_q)
						2'd0:    k = key_q[31:24];
						2'd1:    k = key_q[23:16];
						2'd2:    k = key_q[15:8];
						default: k = key_q[7:0];
					endcase
					left_d      = dec;
					pos_d       = pos_q + 2'd1;
					res.valid   = 1'b1;
					res.payload = b ^ k;
					res.last    = (dec == '0);
					res.status  = ST_PAYLOAD;
					if (dec == '0) begin
						phase_d = PH_SKIP;
					end
				end
			end
			default: begin
			end
		endcase
		if (e) begin
			phase_d = PH_HDR0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			key_q   <= '0;
			left_q  <= '0;
			pos_q   <= 2'd0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			key_q   <= key_d;
			left_q  <= left_d;
			pos_q   <= pos_d;
			bad_q   <= bad_d;
		end
	end

endmodule

// ===== sv/wsd_out_stage.sv =====
// result register of the websocket frame deframer
module wsd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  wsd_pkg::result_t res,
	output logic             out_free,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser
);
	import wsd_pkg::*;

	logic               valid_q;
	logic [ByteW-1:0]   data_q;
	logic               last_q;
	logic [StatusW-1:0] status_q;

	assign out_free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			data_q   <= res.payload;
			last_q   <= res.last;
			status_q <= res.status;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = status_q;

endmodule

// ===== sv/websocket_frame_deframer_core.sv =====
// top level of the websocket client frame deframer
// Takes a received client-to-server websocket buffer one byte per beat on
// s_axis, with tlast on the buffer's last byte. The first byte must carry
// FIN and the text opcode, the second the 7-bit length (126 and 127 are
// rejected), the next four the mask key. Each payload byte leaves on m_axis
// unmasked, with tlast on the frame's final result and the status on tuser:
// 0 payload byte, 1 empty frame, 2 invalid frame (bad header or a buffer
// shorter than six bytes), 3 buffer ended before the payload did. Non-payload
// results carry tdata zero. Bytes past the payload give no beat; any tlast
// returns the block to the start of a new frame. One beat is taken every
// cycle unless stalled; a byte goes through an input register and then the
// result register before its result shows on m_axis. Backpressure on m_axis
// reaches s_axis only once both registers hold data.
module websocket_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // buffer_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic       m_axis_tlast,   // last
	output logic [1:0] m_axis_tuser    // [1:0] status
);
	import wsd_pkg::*;

	logic     valid_s1;
	in_beat_t beat_s1;
	result_t  res;
	logic     out_free;
	logic     advance;

	// a held byte moves on once the result register has room
	assign advance = valid_s1 && out_free;

	wsd_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.beat_s1       (beat_s1)
	);

	// frame state machine and unmasking
	wsd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.beat_s1 (beat_s1),
		.res     (res)
	);

	wsd_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== sv/wsd_checker.sv =====
// port-level checks of the websocket frame deframer and their binding
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic [1:0] m_axis_tuser
);
	import wsd_pkg::*;

	// every status other than payload closes the frame
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_PAYLOAD) |-> m_axis_tlast)
		else $error("non-payload result without tlast");

	// non-payload results carry a zero byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_PAYLOAD) |-> (m_axis_tdata == 8'h00))
		else $error("non-payload result with nonzero data");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// input side keeps taking beats while the result register is free
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |-> s_axis_tready)
		else $error("input stalled with both stages free");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/websocket_frame_deframer_core_tb.sv =====
// self-checking testbench for the websocket frame deframer core
module websocket_frame_deframer_core_tb;
	import wsd_pkg::*;

	localparam int unsigned StallLimit = 2000;
	localparam int unsigned ByteTarget = 750;

	typedef struct packed {
		logic [ByteW-1:0]   payload;
		logic               last;
		logic [StatusW-1:0] status;
	} deframed_t;

	// tracks the receive phase of the block and holds the results still due
	class deframe_scoreboard;
		logic [PhaseW-1:0] phase = PH_HDR0;
		logic [KeyW-1:0]   key = '0;
		logic [LenW-1:0]   left = '0;
		logic [1:0]        key_idx = '0;
		logic              hdr_bad = 1'b0;
		deframed_t         due[$];
		int                errors = 0;

		function int pending();
			return due.size();
		endfunction

		function void note_byte(logic [ByteW-1:0] b, logic buf_end);
			deframed_t r;
			bit emit;
			logic [ByteW-1:0] k;
			emit = 1'b0;
			r.payload = '0;
			r.last = 1'b1;
			r.status = ST_INVALID;
			case (phase)
				PH_HDR0: begin
					hdr_bad = !((b & FinBit) == FinBit && (b & OpcodeMask) == OpcodeText);
					key_idx = '0;
					phase = PH_HDR1;
					emit = buf_end;
				end
				PH_HDR1: begin
					left = LenW'(b & LenMask);
					if (left > MaxLen)
						hdr_bad = 1'b1;
					key_idx = '0;
					phase = PH_MASK;
					emit = buf_end;
				end
				PH_MASK: begin
					key = {key[KeyW-9:0], b};
					if (key_idx != 2'd3) begin
						key_idx = key_idx + 2'd1;
						emit = buf_end;
					end else begin
						// header complete, decide on the frame
						key_idx = '0;
						emit = 1'b1;
						phase = PH_SKIP;
						if (hdr_bad)
							r.status = ST_INVALID;
						else if (left == '0)
							r.status = ST_EMPTY;
						else if (buf_end)
							r.status = ST_TRUNC;
						else begin
							emit = 1'b0;
							phase = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (buf_end && left > 1) begin
						// buffer ran out before the payload did
						r.status = ST_TRUNC;
						emit = 1'b1;
						phase = PH_SKIP;
					end else begin
						k = key[8 * (3 - int'(key_idx)) +: 8];
						left = left - 1'b1;
						key_idx = key_idx + 2'd1;
						r.payload = b ^ k;
						r.last = (left == '0);
						r.status = ST_PAYLOAD;
						emit = 1'b1;
						if (left == '0)
							phase = PH_SKIP;
					end
				end
				default: ;
			endcase
			if (buf_end)
				phase = PH_HDR0;
			if (emit)
				due.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [ByteW-1:0] p, logic l, logic [StatusW-1:0] s);
			deframed_t want;
			if (due.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat tdata %02h tlast %0d tuser %0d",
					p, l, s));
			end else begin
				want = due.pop_front();
				if (p !== want.payload)
					flag_mismatch($sformatf("tdata %02h, want %02h", p, want.payload));
				if (l !== want.last)
					flag_mismatch($sformatf("tlast %0d, want %0d", l, want.last));
				if (s !== want.status)
					flag_mismatch($sformatf("tuser %0d, want %0d", s, want.status));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;

	deframe_scoreboard book = new();
	logic [7:0] buffer_q[$];
	int         beats_sent = 0;
	int         burst_left = 0;
	int         rx_mode = 0;
	int         rx_hold = 0;
	int         rx_tick = 0;

	websocket_frame_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	// receiver stalls: always ready, coin flip, mostly stalled, or a fixed cycle
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_hold = $urandom_range(32, 200);
		end else
			rx_hold--;
		rx_tick++;
		case (rx_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			2: m_axis_tready = ($urandom_range(0, 3) == 0);
			default: m_axis_tready = (rx_tick % 7) >= 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			book.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// one byte beat, with random gaps between bursts
	task send_beat(input logic [7:0] d, input logic buf_end);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				s_axis_tdata = 8'($urandom);
				s_axis_tlast = 1'b0;
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = d;
		s_axis_tlast = buf_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		book.note_byte(d, buf_end);
		burst_left--;
		beats_sent++;
	endtask

	task send_buffer();
		for (int i = 0; i < buffer_q.size(); i++)
			send_beat(buffer_q[i], i == buffer_q.size() - 1);
	endtask

	// hold the sender off until every due result has come out
	task drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	task make_random_buffer();
		int pick;
		int len;
		int cut;
		logic [7:0] tmp;
		buffer_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			// well formed text frame, reserved bits and mask bit random
			tmp = 8'($urandom);
			buffer_q.push_back({1'b1, tmp[6:4], 4'h1});
			cut = $urandom_range(0, 99);
			if (cut < 8)
				len = MaxLen;
			else if (cut < 14)
				len = 0;
			else if (cut < 80)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, 124);
			buffer_q.push_back({tmp[7], 7'(len)});
			repeat (4 + len)
				buffer_q.push_back(8'($urandom));
			cut = $urandom_range(0, 99);
			if (cut >= 85 && len > 0) begin
				// end the buffer on the sixth byte or inside the payload
				cut = $urandom_range(6, 5 + len);
				while (buffer_q.size() > cut)
					void'(buffer_q.pop_back());
			end else if (cut >= 60) begin
				repeat ($urandom_range(1, 4))
					buffer_q.push_back(8'($urandom));
			end
		end else if (pick < 90) begin
			// random header, often an extended length
			buffer_q.push_back(8'($urandom));
			if ($urandom_range(0, 1))
				buffer_q.push_back({1'($urandom), 6'h3F, 1'($urandom)});
			else
				buffer_q.push_back(8'($urandom));
			len = buffer_q[1][6:0];
			if (len > 8)
				len = 0;
			repeat (4 + len + $urandom_range(0, 3))
				buffer_q.push_back(8'($urandom));
		end else begin
			// buffer shorter than a header
			repeat ($urandom_range(1, 5))
				buffer_q.push_back(8'($urandom));
		end
	endtask

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("websocket_frame_deframer_core_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		int next_drain;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed buffers
		buffer_q = '{8'h81};                                   // ends on first byte
		send_buffer();
		buffer_q = '{8'h01, 8'h7E};                            // fin clear, ends on length
		send_buffer();
		buffer_q = '{8'h82, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78}; // wrong opcode, length 127
		send_buffer();
		buffer_q = '{8'h81, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; // empty frame
		send_buffer();
		buffer_q = '{8'h81, 8'h02, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h3C};
		send_buffer();                                         // payload then a trailing byte
		buffer_q = '{8'h81, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}; // ends on the last key byte
		send_buffer();
		drain_results();

		next_drain = beats_sent + $urandom_range(150, 250);
		while (beats_sent < ByteTarget) begin
			make_random_buffer();
			send_buffer();
			if (beats_sent >= next_drain) begin
				drain_results();
				next_drain = beats_sent + $urandom_range(150, 250);
			end
		end

		drain_results();
		repeat (4)
			@(posedge clk);
		if (book.errors == 0)
			$display("websocket_frame_deframer_core_tb OK");
		else
			$display("websocket_frame_deframer_core_tb NOT OK");
		$finish;
	end

endmodule
